// ===== rtl/core/lidar_range_image_projector_top_assert.svh =====
`ifndef LIDAR_RANGE_IMAGE_PROJECTOR_TOP_ASSERT_SVH
`define LIDAR_RANGE_IMAGE_PROJECTOR_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LRIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LRIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lrip_pkg.sv =====
package lrip_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CORRECTION   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BAD_COL = 2'd2;
  localparam logic [1:0] ST_BAD_ROW = 2'd3;

  localparam int UW        = 24;  // CORDIC vector width, covers gain on a 20-bit input
  localparam int ZW        = 18;  // angle accumulator, 16-bit fraction of a turn
  localparam int TABLE_LEN = 24;
  localparam int TURN_HALF = 32768;

  // round(atan(2^-i) / (2 pi) * 65536)
  localparam logic [13:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0,
    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0,   14'd0
  };

  typedef struct packed {
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [12:0] scan_col;
    logic [9:0]  scan_line;
    logic        point_valid;
    logic [23:0] color;
  } point_t;

endpackage

// ===== rtl/core/lidar_range_image_projector_top.sv =====
// Channel | Signals                                     | Dir | Handshake
// input   | point_x point_y scan_col scan_line point_valid | in  | in_valid / in_stall
//         | red green blue                              |     |
// output  | pixel_column pixel_row pixel_color          | out | out_valid / out_stall
//         | write_enable status                         |     |
// config  | cfg_index cfg_data                          | in  | cfg_valid / cfg_ready
//
// One item per cycle sustained while out_stall is low; the pipe holds one register stage per
// CORDIC iteration plus entry, multiply, wrap and output stages.
// Synchronous active-high reset empties the pipe and loads the register defaults.
// Each stage holds only when it is full and the stage after it holds, so bubbles close
// up behind a stalled output and the input keeps flowing until the pipe is full.
// Configuration is always ready.
module lidar_range_image_projector_top
  import lrip_pkg::*;
#(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_HEIGHT       = 256,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] point_x,
  input  logic signed [19:0] point_y,
  input  logic        [12:0] scan_col,
  input  logic        [9:0]  scan_line,
  input  logic               point_valid,
  input  logic        [7:0]  red,
  input  logic        [7:0]  green,
  input  logic        [7:0]  blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [11:0] pixel_column,
  output logic        [7:0]  pixel_row,
  output logic        [23:0] pixel_color,
  output logic               write_enable,
  output logic        [1:0]  status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [12:0] cfg_data
);

  localparam int N    = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;
  localparam int MUL  = N + 1;
  localparam int WRP  = N + 2;
  localparam int LAST = N + 3;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = (HW > 10) ? HW : 10;
  localparam int PW   = ZW + WW + 1;
  localparam int CW   = ((PW - 14) > 14) ? (PW - 14) : 14;

  logic [12:0] image_width;
  logic [8:0]  image_height;
  logic        correction_enable;

  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic signed [WW:0]   w_s;
  logic signed [CW-1:0] w_c;

  logic [LAST:0] vq;
  logic [LAST:0] rdy;

  cordic_t cq [0:N];
  point_t  pq [0:WRP];

  logic signed [ZW-1:0] z_n;
  logic signed [PW-1:0] p_q;
  logic signed [CW-1:0] c1_q;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= 13'd1024;
      image_height      <= 9'd64;
      correction_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width       <= cfg_data;
        REG_IMAGE_HEIGHT: image_height      <= cfg_data[8:0];
        REG_CORRECTION:   correction_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (32'(image_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(image_width);
    h_eff = (32'(image_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(image_height);
    w_s   = $signed({1'b0, w_eff});
    w_c   = $signed(CW'(w_eff));
  end

  // Per-stage flow control
  always_comb begin
    rdy[LAST] = !vq[LAST] || !out_stall;
    for (int s = LAST - 1; s >= 0; s--) begin
      rdy[s] = !vq[s] || rdy[s+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vq[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else begin
      if (rdy[0]) begin
        vq[0] <= in_valid;
      end
      for (int s = 1; s <= LAST; s++) begin
        if (rdy[s]) begin
          vq[s] <= vq[s-1];
        end
      end
    end
  end

  // Entry: fold the left half-plane onto the right
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      cq[0].zero <= (point_x == '0) && (point_y == '0);
      if (point_y < 0) begin
        cq[0].u <= -UW'(point_y);
        cq[0].v <= -UW'(point_x);
        cq[0].z <= (point_x >= 0) ? ZW'(TURN_HALF) : -ZW'(TURN_HALF);
      end else begin
        cq[0].u <= UW'(point_y);
        cq[0].v <= UW'(point_x);
        cq[0].z <= '0;
      end
      pq[0] <= '{scan_col: scan_col, scan_line: scan_line,
                 point_valid: point_valid, color: {red, green, blue}};
    end
  end

  // CORDIC vectoring, one iteration per stage
  for (genvar k = 1; k <= N; k++) begin : g_iter
    localparam int SH = k - 1;
    localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TURNS[k-1]);

    always_ff @(posedge clk) begin
      if (rdy[k] && vq[k-1]) begin
        cq[k].zero <= cq[k-1].zero;
        if (cq[k-1].v >= 0) begin
          cq[k].u <= cq[k-1].u + (cq[k-1].v >>> SH);
          cq[k].v <= cq[k-1].v - (cq[k-1].u >>> SH);
          cq[k].z <= cq[k-1].z + STEP;
        end else begin
          cq[k].u <= cq[k-1].u - (cq[k-1].v >>> SH);
          cq[k].v <= cq[k-1].v + (cq[k-1].u >>> SH);
          cq[k].z <= cq[k-1].z - STEP;
        end
        pq[k] <= pq[k-1];
      end
    end
  end

  // Scale the angle to the image width; a zero vector has angle zero
  assign z_n = cq[N].zero ? '0 : cq[N].z;

  always_ff @(posedge clk) begin
    if (rdy[MUL] && vq[N]) begin
      p_q     <= z_n * w_s;
      pq[MUL] <= pq[N];
    end
  end

  // Truncate toward zero, then wrap negative columns
  logic [PW-1:0]         p_mag;
  logic [PW-17:0]        p_quo;
  logic signed [CW-1:0]  col_t;

  always_comb begin
    p_mag = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);
    p_quo = p_mag[PW-1:16];
    col_t = p_q[PW-1] ? -$signed(CW'(p_quo)) : $signed(CW'(p_quo));
  end

  always_ff @(posedge clk) begin
    if (rdy[WRP] && vq[MUL]) begin
      c1_q    <= (col_t < 0) ? col_t + w_c : col_t;
      pq[WRP] <= pq[MUL];
    end
  end

  // Clamp, select the column source and classify
  logic signed [CW-1:0] c2;
  logic signed [CW-1:0] col_sel;
  logic [1:0]           st_next;

  always_comb begin
    if (c1_q < 0) begin
      c2 = '0;
    end else if (c1_q >= w_c) begin
      c2 = w_c - CW'(1);
    end else begin
      c2 = c1_q;
    end
    col_sel = correction_enable ? c2 : $signed(CW'(pq[WRP].scan_col));
    if (!pq[WRP].point_valid) begin
      st_next = ST_INVALID;
    end else if ((w_eff == '0) || (col_sel >= w_c)) begin
      st_next = ST_BAD_COL;
    end else if (RW'(pq[WRP].scan_line) >= RW'(h_eff)) begin
      st_next = ST_BAD_ROW;
    end else begin
      st_next = ST_WRITTEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST] && vq[WRP]) begin
      status <= st_next;
      if (st_next == ST_WRITTEN) begin
        pixel_column <= col_sel[11:0];
        pixel_row    <= pq[WRP].scan_line[7:0];
        pixel_color  <= pq[WRP].color;
        write_enable <= 1'b1;
      end else begin
        pixel_column <= '0;
        pixel_row    <= '0;
        pixel_color  <= '0;
        write_enable <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/lrip_checker.sv =====
`include "lidar_range_image_projector_top_assert.svh"

module lrip_checker
  import lrip_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] pixel_column,
  input logic [7:0]  pixel_row,
  input logic [23:0] pixel_color,
  input logic        write_enable,
  input logic [1:0]  status
);

  `LRIP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result shown right after reset")
  `LRIP_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(pixel_column) && $stable(pixel_color), "stalled result changed")
  `LRIP_ASSERT(a_we_status, out_valid |-> (write_enable == (status == ST_WRITTEN)), "write enable disagrees with status")
  `LRIP_ASSERT(a_no_write_zero, out_valid && !write_enable |-> (pixel_column == '0) && (pixel_row == '0) && (pixel_color == '0), "fields not cleared without a write")

endmodule

bind lidar_range_image_projector_top lrip_checker u_lrip_checker (.*);
